/* sv/nlmsnc_pkg.sv */
// ----------------------------------------------------------------------------
// NLMS noise canceller package
// Shared sizes, payload structs, register codes and control structs.
// ----------------------------------------------------------------------------
package nlmsnc_pkg;

  localparam int TAPS        = 10;
  localparam int SAMPLE_BITS = 16;

  // sizes derived from the tap count and sample width
  localparam int TAP_IW   = $clog2(TAPS);
  localparam int W_BITS   = 32;
  localparam int W_FRAC   = 28;
  localparam int ACC_W    = W_BITS + SAMPLE_BITS + TAP_IW;
  localparam int SQ_W     = 2 * SAMPLE_BITS - 1;
  localparam int PWR_W    = SQ_W + TAP_IW;
  localparam int EPS_W    = 32;
  localparam int DEN_W    = ((PWR_W > EPS_W) ? PWR_W : EPS_W) + 1;
  localparam int MU_W     = 16;
  localparam int THR_W    = 15;
  localparam int NUM_W    = MU_W + SAMPLE_BITS;
  localparam int GAIN_W   = 40;
  localparam int GAIN_SH  = SAMPLE_BITS + 15;
  localparam int TOP_SH   = GAIN_W - GAIN_SH;
  localparam int CNT_W    = $clog2(TAPS + 1);
  localparam int DIV_CW   = $clog2(GAIN_W + 1);
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 32;

  // register reset values
  localparam logic [MU_W-1:0]  MU_RST  = MU_W'(6144);
  localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(1);
  localparam logic [THR_W-1:0] THR_RST = THR_W'(33);

  typedef enum logic [CFG_IW-1:0] {
    REG_STEP_SIZE   = 2'd0,
    REG_REGULARIZER = 2'd1,
    REG_ERR_THRESH  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] primary_sample;
    logic signed [SAMPLE_BITS-1:0] reference_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] cleaned_sample;
    logic signed [SAMPLE_BITS-1:0] noise_estimate;
  } out_item_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic shift;
    logic acc_en;
    logic mul_g;
    logic upd;
  } cell_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* sv/nlmsnc_cell.sv */
// ----------------------------------------------------------------------------
// NLMS tap cell
// Holds one delay-line sample and one weight; forms w*r and r*r, adds them
// onto the running sums from its left neighbor, and applies its weight step.
// ----------------------------------------------------------------------------
module nlmsnc_cell import nlmsnc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cell_ctl_t                     ctl,
  input  logic signed [SAMPLE_BITS-1:0] ref_in,
  output logic signed [SAMPLE_BITS-1:0] ref_out,
  input  logic signed [ACC_W-1:0]       psum_in,
  output logic signed [ACC_W-1:0]       psum_out,
  input  logic        [PWR_W-1:0]       pwr_in,
  output logic        [PWR_W-1:0]       pwr_out,
  input  logic        [GAIN_W-1:0]      gain,
  input  logic                          err_neg
);

  localparam int PROD_W = W_BITS + SAMPLE_BITS;
  localparam int DLT_W  = GAIN_W + SAMPLE_BITS;
  localparam int STEP_W = GAIN_W + 1;
  localparam int UPD_W  = GAIN_W + 3;

  logic signed [SAMPLE_BITS-1:0] ref_r;
  logic signed [W_BITS-1:0]      w_r, w_nxt;
  logic signed [PROD_W-1:0]      prod_r;
  logic        [SQ_W-1:0]        sq_r;
  logic signed [ACC_W-1:0]       psum_r;
  logic        [PWR_W-1:0]       pwr_r;
  logic        [DLT_W-1:0]       dlt_r;

  logic        [SAMPLE_BITS-1:0]   mag_ref;
  logic        [2*SAMPLE_BITS-1:0] sq_full;
  logic        [STEP_W-1:0]        step;
  logic signed [UPD_W-1:0]         w_ext, step_ext, wsum;
  logic        [UPD_W-W_BITS:0]    wsum_hi;
  logic                            neg;

  assign mag_ref  = ref_r[SAMPLE_BITS-1] ? (~ref_r + 1'b1) : ref_r;
  assign sq_full  = mag_ref * mag_ref;
  assign ref_out  = ref_r;
  assign psum_out = psum_r;
  assign pwr_out  = pwr_r;

  // weight step: delta = g*|r| >> (SAMPLE_BITS-1), signed by e and r
  assign step     = dlt_r[DLT_W-1:SAMPLE_BITS-1];
  assign neg      = err_neg ^ ref_r[SAMPLE_BITS-1];
  assign w_ext    = UPD_W'(w_r);
  assign step_ext = $signed({2'b00, step});
  assign wsum     = neg ? (w_ext - step_ext) : (w_ext + step_ext);
  assign wsum_hi  = wsum[UPD_W-1:W_BITS-1];

  // saturate the updated weight to 32 bits
  always_comb begin
    if ((&wsum_hi) || (~|wsum_hi)) begin
      w_nxt = wsum[W_BITS-1:0];
    end else if (wsum[UPD_W-1]) begin
      w_nxt = {1'b1, {(W_BITS-1){1'b0}}};
    end else begin
      w_nxt = {1'b0, {(W_BITS-1){1'b1}}};
    end
  end

  // delay line and weight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
      w_r   <= '0;
    end else begin
      if (ctl.shift) begin
        ref_r <= ref_in;
      end
      if (ctl.upd) begin
        w_r <= w_nxt;
      end
    end
  end

  // products, running sums and weight step
  always_ff @(posedge clk) begin
    prod_r <= w_r * ref_r;
    sq_r   <= sq_full[SQ_W-1:0];
    if (ctl.acc_en) begin
      psum_r <= psum_in + ACC_W'(prod_r);
      pwr_r  <= pwr_in + PWR_W'(sq_r);
    end
    if (ctl.mul_g) begin
      dlt_r <= gain * mag_ref;
    end
  end

endmodule

/* sv/nlmsnc_div.sv */
// ----------------------------------------------------------------------------
// NLMS gain divider
// Restoring divider, one quotient bit a cycle: g = min(num*2^GAIN_SH / den,
// 2^GAIN_W - 1). An oversized quotient is caught up front and capped.
// ----------------------------------------------------------------------------
module nlmsnc_div import nlmsnc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output div_stat_t         stat,
  output logic [GAIN_W-1:0] gain
);

  logic [DEN_W-1:0]          rem_r, den_r;
  logic [GAIN_W-1:0]         low_r, quo_r;
  logic [DIV_CW-1:0]         cnt_r;
  logic                      busy_r, done_r;

  logic [NUM_W-1:0]          num_hi;
  logic [NUM_W+GAIN_SH-1:0]  num_full;
  logic                      ovf;
  logic [DEN_W:0]            rem2, rem_sub;
  logic                      ge;

  assign num_hi   = num >> TOP_SH;
  assign num_full = {num, {GAIN_SH{1'b0}}};
  assign ovf      = ((NUM_W + DEN_W)'(num_hi) >= (NUM_W + DEN_W)'(den));

  assign rem2     = {rem_r, low_r[GAIN_W-1]};
  assign ge       = (rem2 >= {1'b0, den_r});
  assign rem_sub  = rem2 - {1'b0, den_r};

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign gain      = quo_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !ovf;
        done_r <= ovf;
        cnt_r  <= DIV_CW'(GAIN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: load, then bring down one dividend bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= DEN_W'(num_hi);
      low_r <= num_full[GAIN_W-1:0];
      quo_r <= ovf ? {GAIN_W{1'b1}} : '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem2[DEN_W-1:0];
      low_r <= {low_r[GAIN_W-2:0], 1'b0};
      quo_r <= {quo_r[GAIN_W-2:0], ge};
    end
  end

endmodule

/* sv/nlms_noise_canceller.sv */
// ----------------------------------------------------------------------------
// NLMS noise canceller top level
// Ten-tap normalized LMS canceller built as a row of tap cells, a shared
// serial divider for the normalized gain, and a small sequencer.
// ----------------------------------------------------------------------------
// One item at a time. An item passes from accept to result through the shift,
// product, the sums rippling down the cell row, and evaluate; with
// adaptation the divider step (cut short when the gain saturates up front)
// and the weight update follow. The divider yields one quotient bit a
// cycle.
// Results sit in an output register, so the next item is taken while a
// result still waits; a new result holds in the evaluate step until the
// previous one is taken. Configuration writes are always ready and must only
// arrive while the block is idle.
// ----------------------------------------------------------------------------
module nlms_noise_canceller import nlmsnc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int Y_W = ACC_W + 1 - W_FRAC;
  localparam int E_W = Y_W + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MULT = 8'b0000_0010,
    S_ACC  = 8'b0000_0100,
    S_EVAL = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_GMUL = 8'b0010_0000,
    S_UPD  = 8'b0100_0000,
    S_WAIT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [MU_W-1:0]  mu_r;
  logic [EPS_W-1:0] eps_r;
  logic [THR_W-1:0] thr_r;

  logic signed [SAMPLE_BITS-1:0] primary_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          err_neg_r;
  logic                          out_valid_r;
  out_item_t                     out_data_r;

  cell_ctl_t ctl;
  div_stat_t div_stat;
  logic [GAIN_W-1:0] gain;

  logic signed [SAMPLE_BITS-1:0] ref_q  [TAPS];
  logic signed [ACC_W-1:0]       psum_q [TAPS];
  logic        [PWR_W-1:0]       pwr_q  [TAPS];

  logic signed [ACC_W:0]         t_rnd;
  logic signed [Y_W-1:0]         y_full;
  logic signed [E_W-1:0]         e_full;
  logic signed [SAMPLE_BITS-1:0] e_sat, y_sat;
  logic        [SAMPLE_BITS-1:0] mag_e;
  logic        [DEN_W-1:0]       den;
  logic        [NUM_W-1:0]       num;
  logic                          adapt, eval_go, in_beat;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [E_W-1:0] v);
    logic [E_W-SAMPLE_BITS:0] hi;
    hi = v[E_W-1:SAMPLE_BITS-1];
    if ((&hi) || (~|hi)) begin
      sat_sample = v[SAMPLE_BITS-1:0];
    end else if (v[E_W-1]) begin
      sat_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // cell commands
  assign ctl.shift  = in_beat;
  assign ctl.acc_en = (state_r == S_ACC);
  assign ctl.mul_g  = (state_r == S_GMUL);
  assign ctl.upd    = (state_r == S_UPD);

  // row of tap cells
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    if (i == 0) begin : g_head
      nlmsnc_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .ref_in  (in_data.reference_sample),
        .ref_out (ref_q[i]),
        .psum_in ('0),
        .psum_out(psum_q[i]),
        .pwr_in  ('0),
        .pwr_out (pwr_q[i]),
        .gain    (gain),
        .err_neg (err_neg_r)
      );
    end else begin : g_body
      nlmsnc_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .ref_in  (ref_q[i-1]),
        .ref_out (ref_q[i]),
        .psum_in (psum_q[i-1]),
        .psum_out(psum_q[i]),
        .pwr_in  (pwr_q[i-1]),
        .pwr_out (pwr_q[i]),
        .gain    (gain),
        .err_neg (err_neg_r)
      );
    end
  end

  // estimate, error and gain operands from the end of the row
  assign t_rnd  = (ACC_W + 1)'(psum_q[TAPS-1]) + (ACC_W + 1)'(64'sd1 <<< (W_FRAC - 1));
  assign y_full = t_rnd[ACC_W:W_FRAC];
  assign e_full = E_W'(primary_r) - E_W'(y_full);
  assign e_sat  = sat_sample(e_full);
  assign y_sat  = sat_sample(E_W'(y_full));
  assign mag_e  = e_sat[SAMPLE_BITS-1] ? (~e_sat + 1'b1) : e_sat;
  assign den    = DEN_W'(eps_r) + DEN_W'(pwr_q[TAPS-1]);
  assign num    = mu_r * mag_e;
  assign adapt  = (32'(mag_e) > 32'(thr_r)) && (den != '0);
  assign eval_go = (state_r == S_EVAL) && (!out_valid_r || out_ready);

  nlmsnc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(eval_go && adapt),
    .num  (num),
    .den  (den),
    .stat (div_stat),
    .gain (gain)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_beat) state_nxt = S_MULT;
      S_MULT: state_nxt = S_ACC;
      S_ACC:  if (cnt_r == CNT_W'(TAPS - 1)) state_nxt = S_EVAL;
      S_EVAL: if (eval_go) state_nxt = adapt ? S_WAIT : S_IDLE;
      // a gain capped up front is already done here
      S_WAIT: state_nxt = div_stat.done ? S_GMUL : S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_GMUL;
      S_GMUL: state_nxt = S_UPD;
      S_UPD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ACC) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
      if (eval_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the primary sample, result and error sign
  always_ff @(posedge clk) begin
    if (in_beat) begin
      primary_r <= in_data.primary_sample;
    end
    if (eval_go) begin
      out_data_r.cleaned_sample <= e_sat;
      out_data_r.noise_estimate <= y_sat;
      err_neg_r                 <= e_sat[SAMPLE_BITS-1];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r  <= MU_RST;
      eps_r <= EPS_RST;
      thr_r <= THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_SIZE:   mu_r  <= cfg_data[MU_W-1:0];
        REG_REGULARIZER: eps_r <= cfg_data[EPS_W-1:0];
        REG_ERR_THRESH:  thr_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/nlmsnc_checker.sv */
// ----------------------------------------------------------------------------
// NLMS noise canceller port checker
// Watches the top-level ports: item/result accounting and stall behavior.
// ----------------------------------------------------------------------------
module nlmsnc_checker import nlmsnc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic [1:0] pend_r;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // count items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_beat} - {1'b0, out_beat};
    end
  end

  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_ready)
    else $error("input taken while an item is still at work");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result beat without an outstanding item");

  a_no_pileup: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |-> (pend_r == 2'd0 || pend_r == 2'd1))
    else $error("input taken with two items outstanding");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

endmodule

bind nlms_noise_canceller nlmsnc_checker u_chk (.*);
